// ----- rtl/core/resp_array_parser_core_defines.svh -----
// ----------------------------------------------------------------------------
// resp_array_parser_core_defines.svh
// Assertion macros shared by the RESP array parser RTL.
// ----------------------------------------------------------------------------
`ifndef RESP_ARRAY_PARSER_CORE_DEFINES_SVH
`define RESP_ARRAY_PARSER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define RAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define RAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rap_pkg.sv -----
// ----------------------------------------------------------------------------
// rap_pkg
// Types and constants shared by the RESP array parser modules.
// ----------------------------------------------------------------------------
package rap_pkg;

    // Default width of header numbers, sign bit included
    localparam int NUM_BITS_DEF = 32;

    // Width of the argument index on the result
    localparam int ARG_NUM_W = 32;

    // Framing characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Digit history of the number being read
    typedef enum logic [1:0] {
        DIG_NONE = 2'd0,
        DIG_ZERO = 2'd1,
        DIG_MANY = 2'd2
    } digits_t;

    // Sign and digit history of a header number
    typedef struct packed {
        logic    negative;
        digits_t digits;
    } num_flags_t;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic                 arg_byte_valid;
        logic [7:0]           arg_byte;
        logic [ARG_NUM_W-1:0] arg_number;
        logic                 arg_done;
        logic                 message_done;
        logic                 parse_status;
    } out_item_t;

endpackage

// ----- rtl/core/rap_num_unit.sv -----
// ----------------------------------------------------------------------------
// rap_num_unit
// Folds one character into a header number: sign, leading-zero and overflow
// checks, and the accumulate by ten.
// ----------------------------------------------------------------------------
module rap_num_unit #(
    parameter int NUM_BITS = rap_pkg::NUM_BITS_DEF
) (
    input  logic [7:0]            c,
    input  logic [NUM_BITS-2:0]   acc,
    input  rap_pkg::num_flags_t   flags,
    output logic                  ok,
    output logic [NUM_BITS-2:0]   acc_out,
    output rap_pkg::num_flags_t   flags_out
);
    import rap_pkg::*;

    localparam int AW = NUM_BITS - 1;
    localparam int PW = AW + 4;

    logic          is_digit;
    logic [PW-1:0] acc_w;
    logic [PW-1:0] prod;

    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign acc_w    = PW'(acc);
    // acc * 10 + digit; any bit at AW or above means the limit is passed
    assign prod     = (acc_w << 3) + (acc_w << 1) + PW'(c[3:0]);

    // Apply one character
    always_comb
    begin
        ok        = 1'b1;
        acc_out   = acc;
        flags_out = flags;
        if (c == CH_MINUS)
        begin
            if (flags.digits != DIG_NONE || flags.negative)
                ok = 1'b0;
            else
                flags_out.negative = 1'b1;
        end
        else if (!is_digit)
        begin
            ok = 1'b0;
        end
        else if (flags.digits == DIG_ZERO)
        begin
            ok = 1'b0;
        end
        else if (c == CH_ZERO && flags.digits == DIG_NONE)
        begin
            if (flags.negative)
                ok = 1'b0;
            else
                flags_out.digits = DIG_ZERO;
        end
        else if (prod[PW-1:AW] != '0)
        begin
            ok = 1'b0;
        end
        else
        begin
            acc_out          = prod[AW-1:0];
            flags_out.digits = DIG_MANY;
        end
    end

endmodule

// ----- rtl/core/rap_parser.sv -----
// ----------------------------------------------------------------------------
// rap_parser
// Parse state of the RESP array parser and the next-state logic that turns
// one input item into one result item.
// ----------------------------------------------------------------------------
module rap_parser #(
    parameter int NUM_BITS = rap_pkg::NUM_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  rap_pkg::in_item_t  item,
    output rap_pkg::out_item_t result
);
    import rap_pkg::*;

    localparam int AW = NUM_BITS - 1;

    typedef enum logic [2:0] {
        PH_STAR,
        PH_COUNT,
        PH_DOLLAR,
        PH_LEN,
        PH_PAYLOAD,
        PH_TRAILER,
        PH_END
    } phase_t;

    phase_t               phase_reg,      phase_next;
    logic [AW-1:0]        acc_reg,        acc_next;
    logic [7:0]           held_byte_reg,  held_byte_next;
    logic                 held_valid_reg, held_valid_next;
    num_flags_t           flags_reg,      flags_next;
    logic [AW-1:0]        elements_reg,   elements_next;
    logic [AW-1:0]        bytes_reg,      bytes_next;
    logic [ARG_NUM_W-1:0] cur_arg_reg,    cur_arg_next;
    logic                 error_reg,      error_next;

    logic          feed_ok;
    logic [AW-1:0] feed_acc;
    num_flags_t    feed_flags;
    logic [7:0]    c;
    logic          hdr_nl;
    logic          hdr_bad;

    assign c = item.data_byte;

    // Fold the held header byte into the number
    rap_num_unit #(
        .NUM_BITS (NUM_BITS)
    ) u_num (
        .c         (held_byte_reg),
        .acc       (acc_reg),
        .flags     (flags_reg),
        .ok        (feed_ok),
        .acc_out   (feed_acc),
        .flags_out (feed_flags)
    );

    // Header byte checks: the byte before the newline is never folded in
    assign hdr_nl  = (c == CH_NL);
    assign hdr_bad = hdr_nl ? (flags_reg.digits == DIG_NONE || flags_reg.negative)
                            : (held_valid_reg && !feed_ok);

    // Next state and result for one item
    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        flags_next      = flags_reg;
        elements_next   = elements_reg;
        bytes_next      = bytes_reg;
        cur_arg_next    = cur_arg_reg;
        error_next      = error_reg;

        result              = '0;
        result.message_done = item.end_of_message;

        if (!error_reg)
        begin
            unique case (phase_reg) inside
                PH_STAR, PH_DOLLAR:
                begin
                    if (c == ((phase_reg == PH_STAR) ? CH_STAR : CH_DOLLAR))
                    begin
                        acc_next        = '0;
                        held_byte_next  = '0;
                        held_valid_next = 1'b0;
                        flags_next      = '0;
                        phase_next      = (phase_reg == PH_STAR) ? PH_COUNT : PH_LEN;
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
                PH_COUNT, PH_LEN:
                begin
                    if (hdr_bad)
                    begin
                        error_next = 1'b1;
                    end
                    else if (hdr_nl)
                    begin
                        if (phase_reg == PH_COUNT)
                        begin
                            elements_next = acc_reg;
                            phase_next    = (acc_reg == '0) ? PH_END : PH_DOLLAR;
                        end
                        else if (acc_reg == '0)
                        begin
                            // Empty argument: done on the header newline
                            result.arg_done   = 1'b1;
                            result.arg_number = cur_arg_reg;
                            bytes_next        = AW'(2);
                            phase_next        = PH_TRAILER;
                        end
                        else
                        begin
                            bytes_next = acc_reg;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        if (held_valid_reg)
                        begin
                            acc_next   = feed_acc;
                            flags_next = feed_flags;
                        end
                        held_byte_next  = c;
                        held_valid_next = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    result.arg_byte_valid = 1'b1;
                    result.arg_byte       = c;
                    result.arg_number     = cur_arg_reg;
                    bytes_next            = bytes_reg - AW'(1);
                    if (bytes_reg == AW'(1))
                    begin
                        result.arg_done = 1'b1;
                        bytes_next      = AW'(2);
                        phase_next      = PH_TRAILER;
                    end
                end
                PH_TRAILER:
                begin
                    // Skip the trailer bytes unchecked
                    if (bytes_reg != '0)
                        bytes_next = bytes_reg - AW'(1);
                    if (bytes_reg <= AW'(1))
                    begin
                        cur_arg_next  = cur_arg_reg + ARG_NUM_W'(1);
                        elements_next = elements_reg - AW'(1);
                        phase_next    = (elements_reg == AW'(1)) ? PH_END : PH_DOLLAR;
                    end
                end
                PH_END:
                begin
                    // Trailing byte after a complete array
                    error_next = 1'b1;
                end
                default:
                begin
                    error_next = 1'b1;
                end
            endcase
        end

        // Report status on the last byte and start over
        if (item.end_of_message)
        begin
            result.parse_status = error_next || (phase_next != PH_END);
            phase_next      = PH_STAR;
            acc_next        = '0;
            held_byte_next  = '0;
            held_valid_next = 1'b0;
            flags_next      = '0;
            elements_next   = '0;
            bytes_next      = '0;
            cur_arg_next    = '0;
            error_next      = 1'b0;
        end
    end

    // Hold parse state; advance once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_STAR;
            acc_reg        <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            flags_reg      <= '0;
            elements_reg   <= '0;
            bytes_reg      <= '0;
            cur_arg_reg    <= '0;
            error_reg      <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            flags_reg      <= flags_next;
            elements_reg   <= elements_next;
            bytes_reg      <= bytes_next;
            cur_arg_reg    <= cur_arg_next;
            error_reg      <= error_next;
        end
    end

endmodule

// ----- rtl/core/resp_array_parser_core.sv -----
// ----------------------------------------------------------------------------
// resp_array_parser_core
// Checks a RESP array of bulk strings byte by byte and passes out the
// payload bytes with their argument index.
// ----------------------------------------------------------------------------
// The parser takes one message byte per item and returns exactly one result
// item per input item, sustaining one item every clock cycle while the result
// side is ready. An accepted item is held in the input register, and the parse
// logic turns it into a result that is captured in the result register. The
// parse state updates once per byte; back-pressure on the result side stalls
// both registers. No clearing pass is needed after reset.
module resp_array_parser_core #(
    parameter int NUM_BITS = rap_pkg::NUM_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  rap_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output rap_pkg::out_item_t result
);
    import rap_pkg::*;

    `include "resp_array_parser_core_defines.svh"

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t step_result;
    logic      advance;

    // Move the held item on when the result register is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    rap_parser #(
        .NUM_BITS (NUM_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_item_reg <= item;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // Checks
    `RAP_ASSERT_NOW(a_status_only_at_end, result_valid && result.parse_status,
        result.message_done, "parse_status set without message_done")
    `RAP_ASSERT_NOW(a_byte_zero_when_idle, result_valid && !result.arg_byte_valid,
        result.arg_byte == 8'h00, "arg_byte nonzero without arg_byte_valid")
    `RAP_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, item_ready,
        "input stalled while the result register is empty")
    `RAP_ASSERT_NEXT(a_hold_on_stall, in_valid_reg && out_valid_reg && !result_ready,
        in_valid_reg && $stable(in_item_reg), "held item lost during stall")

endmodule
